### hw/rtl/ccse_pkg.sv
`timescale 1ns / 1ps
// Types, constants and arithmetic helpers shared by the cross cup surface evaluator.
package ccse_pkg;

   typedef struct packed {
      logic [15:0] param_u;
      logic [15:0] param_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic signed [15:0] du_x;
      logic signed [15:0] du_y;
      logic signed [15:0] du_z;
      logic signed [15:0] dv_x;
      logic signed [15:0] dv_y;
      logic signed [15:0] dv_z;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic [17:0] r;
      logic [14:0] q;
   } sqrt_state_type;

   typedef struct packed {
      logic [15:0] r;
      logic [17:0] q;
   } div_state_type;

   typedef struct packed {
      logic ovf;
      logic nneg;
      logic nzero;
      logic szero;
   } zu_flag_type;

   // Odd Taylor coefficients (pi/2)^k / k! in Q30.
   localparam logic [30:0] SIN_C1 = 31'd1686629713;
   localparam logic [30:0] SIN_C3 = 31'd693598668;
   localparam logic [30:0] SIN_C5 = 31'd85569306;
   localparam logic [30:0] SIN_C7 = 31'd5026995;
   localparam logic [30:0] SIN_C9 = 31'd172273;

   localparam logic [15:0] U_ONE = 16'd32768;
   localparam logic [30:0] ONE_Q30 = 31'd1073741824;
   localparam logic signed [31:0] HALF_Q30 = 32'sd536870912;
   localparam logic [15:0] QUARTER_TURN = 16'd16384;
   localparam logic [14:0] PHASE_FULL = 15'd16384;

   localparam int unsigned SQRT_STEPS = 5;
   localparam int unsigned DIV_STEPS = 6;

   // Five steps of the two-bits-at-a-time integer square root.
   function automatic sqrt_state_type sqrt_steps(input sqrt_state_type st,
                                                 input logic [29:0] n,
                                                 input int unsigned top);
      sqrt_state_type res;
      logic [17:0]    trial;
      int unsigned    i;
      res = st;
      for (int unsigned j = 0; j < SQRT_STEPS; j++) begin
         i = top - j;
         res.r = {res.r[15:0], n[2 * i +: 2]};
         trial = {1'b0, res.q, 2'b01};
         if (res.r >= trial) begin
            res.r = res.r - trial;
            res.q = {res.q[13:0], 1'b1};
         end else begin
            res.q = {res.q[13:0], 1'b0};
         end
      end
      return res;
   endfunction

   // Six steps of restoring division of the scaled numerator by s.
   function automatic div_state_type div_steps(input div_state_type st,
                                               input logic [27:0] n,
                                               input logic [14:0] s,
                                               input int unsigned top);
      div_state_type res;
      logic [15:0]   rr;
      int unsigned   i;
      res = st;
      for (int unsigned j = 0; j < DIV_STEPS; j++) begin
         i = top - j;
         rr = {res.r[14:0], n[i]};
         if (rr >= {1'b0, s}) begin
            rr = rr - {1'b0, s};
            res.q = {res.q[16:0], 1'b1};
         end else begin
            res.q = {res.q[16:0], 1'b0};
         end
         res.r = rr;
      end
      return res;
   endfunction

   // Round half up from scale 2^sh to scale 1, then clip to 16 signed bits.
   function automatic logic signed [15:0] rnd_sat(input logic signed [67:0] v,
                                                  input int unsigned sh);
      logic signed [67:0] t;
      t = v + (68'sd1 <<< (sh - 1));
      t = t >>> sh;
      if (t > 68'sd32767) begin
         return 16'sh7fff;
      end
      if (t < -68'sd32768) begin
         return 16'sh8000;
      end
      return t[15:0];
   endfunction

endpackage

### hw/rtl/cross_cup_surface_eval.sv
`timescale 1ns / 1ps
// Cross cup surface point and partial derivatives, pipelined evaluator.
// Throughput: one item per cycle; sine/cosine Horner chains, the square root and
// the du_z divider are all fully pipelined, and the whole pipe stalls on rsp_ready.
// Reset (synchronous) clears the stage valid bits only; the data path is not reset.
module cross_cup_surface_eval (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ccse_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ccse_pkg::rsp_type rsp_data
);

   localparam int unsigned LAST = 14;

   logic            adv;
   logic [LAST:1]   vld_ff;
   logic [LAST:1]   vld_in;

   // Sine (lane 0) and cosine (lane 1) chains.
   logic [14:0]        ph_ff   [2][1:5];
   logic [1:0]         quad_ff [2][1:6];
   logic [30:0]        x2_ff   [2][1:4];
   logic [30:0]        t_ff    [2][2:5];
   logic [31:0]        p_ff    [2];
   logic signed [16:0] trig_ff [2];
   logic [14:0]        ph_in   [2];
   logic [1:0]         quad_in [2];
   logic [30:0]        x2_in   [2];
   logic [30:0]        t_in    [2][2:5];
   logic [31:0]        p_in    [2];
   logic signed [16:0] trig_in [2];

   logic [15:0] u_ff  [1:9];
   logic [30:0] uu_ff [2:10];
   logic [15:0] u_in;

   ccse_pkg::sqrt_state_type sq_ff [3:4];
   ccse_pkg::sqrt_state_type sq3_in, sq4_in, sq5_in;
   logic [29:0] n_ff [3:4];
   logic [29:0] n_in;
   logic [14:0] s_ff [5:12];

   logic signed [31:0] sv2_ff [8:9];
   logic signed [31:0] cv2_ff [8:9];
   logic signed [31:0] sc_ff  [8:9];
   logic signed [17:0] ssum_ff [8:9];
   logic signed [17:0] sdif_ff [8:9];
   logic [30:0]        us_ff [8:9];
   logic signed [33:0] sv2_w, cv2_w, sc_w;
   logic [30:0]        us_in;

   logic signed [32:0] ysum_ff, yvsum_ff;
   logic signed [34:0] yusum_ff;
   logic signed [49:0] num_ff;
   logic signed [31:0] d29;

   logic signed [63:0] px_ff, py_ff, pz_ff, dux_ff, duy_ff, dvx_ff, dvy_ff, dvz_ff;
   logic [49:0]        mag;
   logic [49:0]        nsum;
   logic [27:0]        nb_ff [10:12];
   logic [27:0]        nb_in;
   ccse_pkg::zu_flag_type flg_ff [10:13];
   ccse_pkg::zu_flag_type flg_in;

   ccse_pkg::div_state_type dv_ff [11:12];
   ccse_pkg::div_state_type dv11_in, dv12_in, dv13_in, dv_init;
   logic [17:0] dq_ff;

   ccse_pkg::rsp_type res_ff [11:LAST];
   ccse_pkg::rsp_type res11_in, res14_in;
   logic signed [67:0] wx;
   logic signed [16:0] negq;

   // The output register is the last stage; everything moves when it can drain.
   assign adv       = !vld_ff[LAST] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[LAST];
   assign rsp_data  = res_ff[LAST];
   assign vld_in    = {vld_ff[LAST-1:1], req_valid};

   // Front end: clamp u, fold both angles into the first quadrant, and run the sine/cosine Horner chains.
   always_comb begin
      logic [15:0] a;
      logic [14:0] ph;
      logic [29:0] ph2;
      logic [61:0] m;
      logic [30:0] d;
      logic [45:0] m6;
      logic [30:0] pc;
      logic [31:0] rr;
      logic [16:0] mag17;
      u_in = (req_data.param_u > ccse_pkg::U_ONE) ? ccse_pkg::U_ONE : req_data.param_u;
      for (int l = 0; l < 2; l++) begin
         a = req_data.param_angle + ((l == 1) ? ccse_pkg::QUARTER_TURN : 16'd0);
         quad_in[l] = a[15:14];
         ph = {1'b0, a[13:0]};
         if (a[14]) begin
            ph = ccse_pkg::PHASE_FULL - ph;
         end
         ph_in[l] = ph;
         ph2 = 30'(ph) * 30'(ph);
         x2_in[l] = {ph2[28:0], 2'b00};

         m = 62'(ccse_pkg::SIN_C9) * 62'(x2_ff[l][1]);
         t_in[l][2] = m[60:30];
         d = ccse_pkg::SIN_C7 - t_ff[l][2];
         m = 62'(d) * 62'(x2_ff[l][2]);
         t_in[l][3] = m[60:30];
         d = ccse_pkg::SIN_C5 - t_ff[l][3];
         m = 62'(d) * 62'(x2_ff[l][3]);
         t_in[l][4] = m[60:30];
         d = ccse_pkg::SIN_C3 - t_ff[l][4];
         m = 62'(d) * 62'(x2_ff[l][4]);
         t_in[l][5] = m[60:30];

         // Last Horner step multiplies by x = phase << 16, hence the shift of 14.
         d = ccse_pkg::SIN_C1 - t_ff[l][5];
         m6 = 46'(d) * 46'(ph_ff[l][5]);
         p_in[l] = m6[45:14];

         pc = (p_ff[l] > 32'(ccse_pkg::ONE_Q30)) ? ccse_pkg::ONE_Q30 : p_ff[l][30:0];
         rr = (32'(pc) + 32'd16384) >> 15;
         mag17 = {1'b0, rr[15:0]};
         trig_in[l] = quad_ff[l][6][1] ? -$signed(mag17) : $signed(mag17);
      end
   end

   // Square root of (1 - u^2) / 2 in three stages.
   always_comb begin
      logic [30:0] diff;
      diff   = ccse_pkg::ONE_Q30 - uu_ff[2];
      n_in   = diff[30:1];
      sq3_in = ccse_pkg::sqrt_steps('0, n_in, 14);
      sq4_in = ccse_pkg::sqrt_steps(sq_ff[3], n_ff[3], 9);
      sq5_in = ccse_pkg::sqrt_steps(sq_ff[4], n_ff[4], 4);
   end

   always_comb begin
      sv2_w = trig_ff[0] * trig_ff[0];
      cv2_w = trig_ff[1] * trig_ff[1];
      sc_w  = trig_ff[0] * trig_ff[1];
      us_in = 31'(u_ff[7]) * 31'(s_ff[7]);
      d29   = ccse_pkg::HALF_Q30 - $signed({1'b0, uu_ff[8]});
   end

   // Magnitude of the du_z numerator with half the divisor added, prescaled by 2^-18.
   always_comb begin
      mag  = num_ff[49] ? 50'(-num_ff) : 50'(num_ff);
      nsum = mag + 50'({s_ff[9], 17'd0});
      nb_in = nsum[45:18];
      flg_in.ovf   = 32'(nb_in) >= {s_ff[9], 17'd0};
      flg_in.nneg  = num_ff[49];
      flg_in.nzero = (num_ff == '0);
      flg_in.szero = (s_ff[9] == '0);
   end

   always_comb begin
      dv_init = '0;
      dv_init.r = {6'd0, nb_ff[10][27:18]};
      dv11_in = ccse_pkg::div_steps(dv_init, nb_ff[10], s_ff[10], 17);
      dv12_in = ccse_pkg::div_steps(dv_ff[11], nb_ff[11], s_ff[11], 11);
      dv13_in = ccse_pkg::div_steps(dv_ff[12], nb_ff[12], s_ff[12], 5);
   end

   always_comb begin
      res11_in = '0;
      wx = (68'sd1 <<< 60) - $signed({7'd0, uu_ff[10], 30'd0}) + 68'(px_ff);
      res11_in.pos_x = ccse_pkg::rnd_sat(wx, 48);
      res11_in.pos_y = ccse_pkg::rnd_sat(68'(py_ff), 48);
      res11_in.pos_z = ccse_pkg::rnd_sat(68'(pz_ff), 33);
      res11_in.du_x  = ccse_pkg::rnd_sat(-(68'(dux_ff) <<< 1), 33);
      res11_in.du_y  = ccse_pkg::rnd_sat(68'(duy_ff), 33);
      res11_in.dv_x  = ccse_pkg::rnd_sat(68'(dvx_ff) <<< 1, 48);
      res11_in.dv_y  = ccse_pkg::rnd_sat(68'(dvy_ff) <<< 1, 48);
      res11_in.dv_z  = ccse_pkg::rnd_sat(68'(dvz_ff), 33);
   end

   always_comb begin
      res14_in = res_ff[13];
      negq = -$signed({1'b0, dq_ff[15:0]});
      res14_in.saturated = 1'b0;
      if (flg_ff[13].szero) begin
         res14_in.saturated = 1'b1;
         if (flg_ff[13].nzero) begin
            res14_in.du_z = '0;
         end else if (flg_ff[13].nneg) begin
            res14_in.du_z = 16'sh8000;
         end else begin
            res14_in.du_z = 16'sh7fff;
         end
      end else if (!flg_ff[13].nneg) begin
         if (flg_ff[13].ovf || dq_ff > 18'd32767) begin
            res14_in.du_z = 16'sh7fff;
            res14_in.saturated = 1'b1;
         end else begin
            res14_in.du_z = $signed(dq_ff[15:0]);
         end
      end else begin
         if (flg_ff[13].ovf || dq_ff > 18'd32768) begin
            res14_in.du_z = 16'sh8000;
            res14_in.saturated = 1'b1;
         end else begin
            res14_in.du_z = negq[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 2; l++) begin
            ph_ff[l][1]   <= ph_in[l];
            quad_ff[l][1] <= quad_in[l];
            x2_ff[l][1]   <= x2_in[l];
            for (int k = 2; k <= 5; k++) begin
               ph_ff[l][k] <= ph_ff[l][k-1];
               t_ff[l][k]  <= t_in[l][k];
            end
            for (int k = 2; k <= 6; k++) begin
               quad_ff[l][k] <= quad_ff[l][k-1];
            end
            for (int k = 2; k <= 4; k++) begin
               x2_ff[l][k] <= x2_ff[l][k-1];
            end
            p_ff[l]    <= p_in[l];
            trig_ff[l] <= trig_in[l];
         end

         u_ff[1] <= u_in;
         for (int k = 2; k <= 9; k++) begin
            u_ff[k] <= u_ff[k-1];
         end
         uu_ff[2] <= 31'(u_ff[1]) * 31'(u_ff[1]);
         for (int k = 3; k <= 10; k++) begin
            uu_ff[k] <= uu_ff[k-1];
         end

         sq_ff[3] <= sq3_in;
         sq_ff[4] <= sq4_in;
         n_ff[3]  <= n_in;
         n_ff[4]  <= n_ff[3];
         s_ff[5]  <= sq5_in.q;
         for (int k = 6; k <= 12; k++) begin
            s_ff[k] <= s_ff[k-1];
         end

         sv2_ff[8]  <= sv2_w[31:0];
         cv2_ff[8]  <= cv2_w[31:0];
         sc_ff[8]   <= sc_w[31:0];
         ssum_ff[8] <= 18'(trig_ff[0]) + 18'(trig_ff[1]);
         sdif_ff[8] <= 18'(trig_ff[1]) - 18'(trig_ff[0]);
         us_ff[8]   <= us_in;
         sv2_ff[9]  <= sv2_ff[8];
         cv2_ff[9]  <= cv2_ff[8];
         sc_ff[9]   <= sc_ff[8];
         ssum_ff[9] <= ssum_ff[8];
         sdif_ff[9] <= sdif_ff[8];
         us_ff[9]   <= us_ff[8];

         ysum_ff  <= 33'(sv2_ff[8]) + (33'(sc_ff[8]) <<< 1);
         yusum_ff <= (35'(sc_ff[8]) <<< 2) + (35'(sv2_ff[8]) <<< 1);
         yvsum_ff <= 33'(cv2_ff[8]) + 33'(sc_ff[8]) - 33'(sv2_ff[8]);
         num_ff   <= d29 * ssum_ff[8];

         px_ff  <= $signed({1'b0, uu_ff[9]}) * sv2_ff[9];
         py_ff  <= $signed({1'b0, uu_ff[9]}) * ysum_ff;
         pz_ff  <= $signed({1'b0, us_ff[9]}) * ssum_ff[9];
         dux_ff <= $signed({1'b0, u_ff[9]}) * cv2_ff[9];
         duy_ff <= $signed({1'b0, u_ff[9]}) * yusum_ff;
         dvx_ff <= $signed({1'b0, uu_ff[9]}) * sc_ff[9];
         dvy_ff <= $signed({1'b0, uu_ff[9]}) * yvsum_ff;
         dvz_ff <= $signed({1'b0, us_ff[9]}) * sdif_ff[9];

         nb_ff[10]  <= nb_in;
         nb_ff[11]  <= nb_ff[10];
         nb_ff[12]  <= nb_ff[11];
         flg_ff[10] <= flg_in;
         for (int k = 11; k <= 13; k++) begin
            flg_ff[k] <= flg_ff[k-1];
         end
         dv_ff[11] <= dv11_in;
         dv_ff[12] <= dv12_in;
         dq_ff     <= dv13_in.q;

         res_ff[11]   <= res11_in;
         res_ff[12]   <= res_ff[11];
         res_ff[13]   <= res_ff[12];
         res_ff[LAST] <= res14_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      vld_ff[6] && adv |=> vld_ff[7])
      else $error("pipeline stage dropped an item");

   a_div_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[13] && !flg_ff[13].ovf && !flg_ff[13].szero |-> !dq_ff[17])
      else $error("du_z quotient exceeds its range without overflow");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         (rsp_data.du_z == 16'sh7fff || rsp_data.du_z == 16'sh8000 ||
          rsp_data.du_z == 16'sh0000))
      else $error("saturated flag with an unclipped du_z");

endmodule
